// File: hw/rtl/fir49_pkg.sv
// Shared constants, tap weights and status types for the 49-tap low-pass FIR.
// Used by fir49_tap_cell, fir49_div and fir_lowpass_49_tap_unit.
package fir49_pkg;

	// Default sample width and fixed filter geometry.
	localparam int SAMPLE_WIDTH = 16;
	localparam int TAP_COUNT    = 49;
	localparam int OUT_W        = 18;

	// The accumulator needs 16 bits above the sample: the sum of |weights| is below 2^15.
	localparam int ACC_GROWTH   = 16;

	// Pipeline stages from the tap chain output to the output register.
	localparam int STAGES       = 4;

	// Tap weights scaled by 10000; index 0 multiplies the newest sample.
	localparam int TapWeight [TAP_COUNT] = '{
		46, 74, -24, -71, 33, 1, -94, 40, 44, -133,
		30, 114, -179, -11, 223, -225, -109, 396, -263, -348,
		752, -289, -1204, 2879, 6369, 2879, -1204, -289, 752, -338,
		-263, 396, -109, -225, 223, -11, -179, 114, 30, 133,
		44, 40, -94, 1, 33, -71, -24, 74, 46
	};

	// Stage valid bits, reported from the divider pipeline to the top level.
	typedef struct packed {
		logic [STAGES-1:0] vld;
	} fir49_pipe_st_t;

endpackage

// File: hw/rtl/fir49_tap_cell.sv
// One cell of the transposed-form tap chain: constant multiply plus partial sum register.
// Depends on fir49_pkg for the default sample width.
module fir49_tap_cell import fir49_pkg::*; #(
	parameter int SAMPLE_WIDTH = fir49_pkg::SAMPLE_WIDTH,
	parameter int ACC_W        = fir49_pkg::SAMPLE_WIDTH + fir49_pkg::ACC_GROWTH,
	parameter int COEF         = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] x,
	input  logic signed [ACC_W-1:0]        z_in,
	output logic signed [ACC_W-1:0]        z_out
);

	localparam logic signed [ACC_W-1:0] CoefExt = ACC_W'(COEF);

	logic signed [ACC_W-1:0] x_ext;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] z_q;

	// Weighted sample joins the partial sum handed over by the older neighbor.
	assign x_ext = ACC_W'(x);
	assign prod  = x_ext * CoefExt;

	// The partial sum moves one place toward the output on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_q <= '0;
		end else if (en) begin
			z_q <= prod + z_in;
		end
	end

	assign z_out = z_q;

endmodule

// File: hw/rtl/fir49_div.sv
// Divide-by-10000 pipeline with truncation toward zero and 18-bit saturation,
// plus the stage handshake. Depends on fir49_pkg.
module fir49_div import fir49_pkg::*; #(
	parameter int ACC_W = fir49_pkg::SAMPLE_WIDTH + fir49_pkg::ACC_GROWTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    take,
	input  logic signed [ACC_W-1:0] acc_s1,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] filtered,
	output fir49_pipe_st_t          st
);

	// Magnitudes at or above LIMIT saturate, so only 31 bits need exact division.
	localparam int MW        = (ACC_W > 31) ? ACC_W : 31;
	localparam int QMAX      = 1 << (OUT_W - 1);
	localparam longint LIMIT = longint'(QMAX) * 10000;
	localparam int MQ_W      = 27;
	localparam int RSH       = 37;
	localparam int RW        = 28;
	localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RSH) + 64'd624) / 64'd625);
	localparam int PW        = MQ_W + RW;

	logic [STAGES-1:0] vld_q;
	logic [STAGES:0]   rdy;

	logic [MW-1:0]     mag;
	logic [MW-1:0]     mag_c;
	logic [PW-1:0]     prod;

	logic [MQ_W-1:0]   m_s2;
	logic              neg_s2;
	logic [OUT_W-1:0]  q_s3;
	logic              neg_s3;
	logic [OUT_W-1:0]  y_s4;

	// Each stage may load when it is empty or its successor moves on.
	always_comb begin
		rdy[STAGES] = out_ready;
		for (int i = STAGES - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign take = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Stage 2: magnitude, clamp, and the free divide by 16.
	assign mag   = MW'($unsigned(acc_s1[ACC_W-1] ? -acc_s1 : acc_s1));
	assign mag_c = (mag > MW'(LIMIT)) ? MW'(LIMIT) : mag;

	always_ff @(posedge clk) begin
		if (rdy[1] && vld_q[0]) begin
			m_s2   <= mag_c[MQ_W+3:4];
			neg_s2 <= acc_s1[ACC_W-1];
		end
	end

	// Stage 3: divide by 625 through a reciprocal; exact below 2^27.
	assign prod = PW'(m_s2) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (rdy[2] && vld_q[1]) begin
			q_s3   <= prod[RSH+OUT_W-1:RSH];
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: restore the sign; only the positive side can exceed the range.
	always_ff @(posedge clk) begin
		if (rdy[3] && vld_q[2]) begin
			if (neg_s3) begin
				y_s4 <= -q_s3;
			end else if (q_s3 > OUT_W'(QMAX - 1)) begin
				y_s4 <= OUT_W'(QMAX - 1);
			end else begin
				y_s4 <= q_s3;
			end
		end
	end

	assign out_valid = vld_q[STAGES-1];
	assign filtered  = $signed(y_s4);
	assign st.vld    = vld_q;

endmodule

// File: hw/rtl/fir_lowpass_49_tap_unit.sv
// Top level of the 49-tap low-pass FIR: tap cell chain and divide pipeline.
// Depends on fir49_pkg, fir49_tap_cell and fir49_div.

// The filter takes one sample per clock cycle while in_ready is high and returns one filtered
// value per sample, in order, through four registered stages. The taps sit in a transposed
// chain of 49 cells, each holding one partial sum, so the sum for a sample is complete in the
// register of the first cell in the cycle after acceptance; three more stages divide it by
// 10000 (truncating toward zero) and saturate it to 18 bits. Up to four items can be in
// flight, and in_ready drops only when all four stages are full and out_ready is low.
module fir_lowpass_49_tap_unit import fir49_pkg::*; #(
	parameter int SAMPLE_WIDTH = fir49_pkg::SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [OUT_W-1:0]        filtered
);

	localparam int ACC_W = SAMPLE_WIDTH + ACC_GROWTH;

	logic                    take;
	logic                    shift_en;
	logic signed [ACC_W-1:0] z [TAP_COUNT+1];
	fir49_pipe_st_t          st;

	// The whole chain advances on each accepted item.
	assign in_ready  = take;
	assign shift_en  = in_valid && take;
	assign z[TAP_COUNT] = '0;

	// Cell k carries weight k; cell 0 holds the finished sum.
	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
		fir49_tap_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.ACC_W       (ACC_W),
			.COEF        (TapWeight[k])
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (shift_en),
			.x     (sample),
			.z_in  (z[k+1]),
			.z_out (z[k])
		);
	end

	// Scaling, rounding toward zero, saturation and the output handshake.
	fir49_div #(
		.ACC_W(ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.take     (take),
		.acc_s1   (z[0]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered (filtered),
		.st       (st)
	);

`ifndef NO_ASSERTIONS
	// Input stalls only when every stage is full behind a stalled output.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && (&st.vld)))
		else $error("input stalled while the pipeline had room");

	// An accepted item fills the first stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> st.vld[0])
		else $error("accepted item did not reach the first stage");

	// A new result appears only from a filled third stage.
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st.vld[STAGES-2]))
		else $error("result appeared without an item behind it");
`endif

endmodule

// File: verif/fir49_lowpass_checker.sv
// Checker for the 49-tap low-pass FIR: watches both item channels, predicts each
// filtered value and compares it with what the unit returns. Depends on fir49_pkg.
module fir49_lowpass_checker import fir49_pkg::*; #(
	parameter int SW = fir49_pkg::SAMPLE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [SW-1:0]               sample,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [fir49_pkg::OUT_W-1:0] filtered,
	output int                                 mismatches,
	output int                                 samples_in,
	output int                                 values_out,
	output int                                 peak_abs
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     NTAPS  = 49;
	localparam longint SCALE  = 10000;
	localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint OUT_LO = -(longint'(1) << (OUT_W - 1));

	// Filter weights scaled by 10000; entry 0 weighs the newest sample.
	localparam int LP_COEF [NTAPS] = '{
		46, 74, -24, -71, 33, 1, -94, 40, 44, -133,
		30, 114, -179, -11, 223, -225, -109, 396, -263, -348,
		752, -289, -1204, 2879, 6369, 2879, -1204, -289, 752, -338,
		-263, 396, -109, -225, 223, -11, -179, 114, 30, 133,
		44, 40, -94, 1, 33, -71, -24, 74, 46
	};

	// Previous samples, entry 0 the most recent one.
	logic signed [SW-1:0]    delay_line [NTAPS-1];
	// Filtered values still owed by the unit, oldest first.
	logic signed [OUT_W-1:0] filtered_due [$];

	// Weighted sum over the new sample and the delay line, divided toward zero and clamped.
	function automatic logic signed [OUT_W-1:0] lowpass_value(input logic signed [SW-1:0] newest);
		longint acc;
		longint quo;
		acc = longint'(LP_COEF[0]) * longint'(newest);
		for (int i = 0; i < NTAPS - 1; i++)
			acc += longint'(LP_COEF[i + 1]) * longint'(delay_line[i]);
		quo = acc / SCALE;
		if (quo > OUT_HI)
			quo = OUT_HI;
		if (quo < OUT_LO)
			quo = OUT_LO;
		return quo[OUT_W-1:0];
	endfunction

	// One line per failure, and the count goes up.
	task automatic report_mismatch(input string what);
		$display("%0t ns: result %0d: %s", $time, values_out, what);
		mismatches <= mismatches + 1;
	endtask

	// Prediction on accepted samples, comparison on accepted results.
	always @(posedge clk or negedge arst_n) begin
		logic signed [OUT_W-1:0] want;
		int                      mag;
		if (!arst_n) begin
			for (int i = 0; i < NTAPS - 1; i++)
				delay_line[i] <= '0;
			filtered_due.delete();
			mismatches <= 0;
			samples_in <= 0;
			values_out <= 0;
			peak_abs   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (filtered_due.size() == 0) begin
					report_mismatch($sformatf("unexpected filtered value %0d", filtered));
				end else begin
					want = filtered_due.pop_front();
					if (filtered !== want)
						report_mismatch($sformatf("filtered expected %0d, got %0d",
							want, filtered));
				end
				values_out <= values_out + 1;
			end
			if (in_valid && in_ready) begin
				want = lowpass_value(sample);
				filtered_due.push_back(want);
				mag = int'(want);
				if (mag < 0)
					mag = -mag;
				if (mag > peak_abs)
					peak_abs <= mag;
				delay_line[0] <= sample;
				for (int i = 1; i < NTAPS - 1; i++)
					delay_line[i] <= delay_line[i - 1];
				samples_in <= samples_in + 1;
			end
		end
	end

endmodule

// File: verif/tb_fir_lowpass_49_tap_unit.sv
// Testbench top for fir_lowpass_49_tap_unit: clock, reset, sample stimulus with random
// pacing on both channels, a watchdog and the verdict. Depends on fir49_pkg and the checker.
module tb_fir_lowpass_49_tap_unit import fir49_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW          = fir49_pkg::SAMPLE_WIDTH;
	localparam int ITEM_TARGET = 1750;
	localparam int MAX_WAIT    = 18;
	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN       = 24;
	localparam int SMP_MAX     = (1 << (SW - 1)) - 1;
	localparam int SMP_MIN     = -(1 << (SW - 1));

	// Short opening sequence: extremes, sign flips, bit patterns and small negatives.
	localparam int DIRECTED [22] = '{
		0, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, -1, 1, 0, 'h5555, -'h5556,
		SMP_MIN, SMP_MIN, SMP_MIN, SMP_MAX, SMP_MAX, SMP_MAX, -3, 2, -1, -7, 0, 0
	};

	typedef enum int {PACE_NONE, PACE_FULL, PACE_LIGHT} pace_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [SW-1:0]    sample;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [OUT_W-1:0] filtered;

	int    mismatches;
	int    samples_in;
	int    values_out;
	int    peak_abs;
	int    sent;
	int    taken;
	int    idle_cycles;
	pace_t send_pace;
	pace_t take_pace;

	fir_lowpass_49_tap_unit #(.SAMPLE_WIDTH(SW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered (filtered)
	);

	fir49_lowpass_checker #(.SW(SW)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.mismatches(mismatches),
		.samples_in(samples_in),
		.values_out(values_out),
		.peak_abs  (peak_abs)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Cycles to hold off before the next item on one side.
	function automatic int draw_wait(input pace_t p);
		case (p)
			PACE_FULL: begin
				return int'($urandom_range(0, MAX_WAIT));
			end
			PACE_LIGHT: begin
				return ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, MAX_WAIT)) : 0;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// Offers one sample and returns at the edge where it is taken.
	task automatic push_sample(input int v);
		int gap;
		gap = draw_wait(send_pace);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v[SW-1:0];
		do @(posedge clk); while (!in_ready);
		sent++;
		if (sent % 50 == 0)
			send_pace = pace_t'($urandom_range(0, 2));
	endtask

	// Sample stream: directed opening, then random segments of several shapes.
	initial begin : sample_source
		int kind;
		int seg_len;
		int flip;
		int amp;
		in_valid  <= 1'b0;
		sample    <= '0;
		arst_n    <= 1'b0;
		sent      = 0;
		send_pace = PACE_NONE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			push_sample(DIRECTED[i]);
		while (sent < ITEM_TARGET) begin
			kind = int'($urandom_range(0, 9));
			if (kind <= 3) begin
				// Uniform data over the whole sample range.
				seg_len = int'($urandom_range(10, 80));
				repeat (seg_len) push_sample(int'($urandom()));
			end else if (kind == 4) begin
				// Runs of extreme and near-zero values.
				seg_len = int'($urandom_range(5, 40));
				repeat (seg_len) begin
					case ($urandom_range(0, 4))
						0: push_sample(SMP_MAX);
						1: push_sample(SMP_MIN);
						2: push_sample(-1);
						3: push_sample(1);
						default: push_sample(0);
					endcase
				end
			end else if (kind <= 6) begin
				// Full-scale samples whose signs follow the weights: drives the
				// output to its largest positive or negative magnitude.
				flip = int'($urandom_range(0, 1));
				for (int k = TAP_COUNT - 1; k >= 0; k--) begin
					if ((TapWeight[k] > 0) ^ (flip != 0))
						push_sample(SMP_MAX);
					else
						push_sample(SMP_MIN);
				end
			end else if (kind <= 8) begin
				// Small values: sums near zero exercise truncation of negative quotients.
				seg_len = int'($urandom_range(10, 60));
				repeat (seg_len) push_sample(int'($urandom_range(0, 10)) - 5);
			end else begin
				// Impulse followed by zeros walks the value across as many weights as the run of zeros reaches.
				amp = int'($urandom());
				push_sample(amp);
				seg_len = int'($urandom_range(10, 50));
				repeat (seg_len) push_sample(0);
			end
		end
		in_valid <= 1'b0;

		// Drain every outstanding value, then give stray results time to show up.
		@(posedge clk);
		while (samples_in != values_out) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("Run covered %0d samples and %0d filtered values, %0d mismatches, peak |out| %0d.",
			samples_in, values_out, mismatches, peak_abs);
		$display("Stimulus mixed extremes, weight-matched full-scale runs, impulses and small data.");
		if (mismatches == 0)
			$display("tb_fir_lowpass_49_tap_unit OK");
		else
			$display("tb_fir_lowpass_49_tap_unit NOT OK");
		$finish;
	end

	// Result side: random stalls per item, changing pace every fifty items.
	initial begin : result_sink
		int gap;
		out_ready <= 1'b0;
		taken     = 0;
		take_pace = PACE_NONE;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = draw_wait(take_pace);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken % 50 == 0)
				take_pace = pace_t'($urandom_range(0, 2));
		end
	end

	// Watchdog: too many cycles without an item moving on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no item accepted for %0d cycles.", IDLE_LIMIT);
			$display("tb_fir_lowpass_49_tap_unit NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
